>>> sv/saag_pkg.sv
`default_nettype none
package saag_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_BITS = 16;
  localparam int DIM_BITS = 2;
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 64;
  localparam int INDEX_BITS = 32;
  localparam int OFFSET_BITS = 32;
  localparam int RANK_BITS = 3;
  localparam int BASE_BITS = 16;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES = INDEX_BITS / DIV_BITS_PER_CYCLE;
  localparam int STEP_BITS = $clog2(DIV_CYCLES);
  localparam int MAC_CNT_BITS = 3;

  localparam logic [DATA_BITS-1:0] RESET_ONES = 64'h0001_0001_0001_0001;
  localparam logic [RANK_BITS-1:0] RESET_RANK = 3'd1;

  typedef enum logic [1:0] {
    REG_RANK    = 2'd0,
    REG_BASE    = 2'd1,
    REG_SIZES   = 2'd2,
    REG_STRIDES = 2'd3
  } reg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic                load;
    logic                div_init;
    logic                div_step;
    logic                store;
    logic                set_err;
    logic                mac_step;
    logic                mac_use;
    logic [DIM_BITS-1:0] dim;
    logic [DIM_BITS-1:0] mac_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic size_zero;
  } dp_status_t;

  // Dimension 0 sits in the top 16 bits.
  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [DATA_BITS-1:0] word,
                                                   input logic [DIM_BITS-1:0] d);
    logic [SLOT_BITS-1:0] s;
    case (d)
      2'd0: s = word[63:48];
      2'd1: s = word[47:32];
      2'd2: s = word[31:16];
      2'd3: s = word[15:0];
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/saag_regs.sv
`default_nettype none
module saag_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [saag_pkg::ADDR_BITS-1:0]       paddr,
  input  wire logic [saag_pkg::DATA_BITS-1:0]       pwdata,
  output logic      [saag_pkg::DATA_BITS-1:0]       prdata,
  output logic                                      pready,
  output logic      [saag_pkg::RANK_BITS-1:0]       rank,
  output logic      [saag_pkg::BASE_BITS-1:0]       base_offset,
  output logic      [saag_pkg::DATA_BITS-1:0]       dim_sizes,
  output logic      [saag_pkg::DATA_BITS-1:0]       strides
);

  logic [saag_pkg::RANK_BITS-1:0] rank_r;
  logic [saag_pkg::BASE_BITS-1:0] base_r;
  logic [saag_pkg::DATA_BITS-1:0] sizes_r;
  logic [saag_pkg::DATA_BITS-1:0] strides_r;
  logic                           wr_en;
  saag_pkg::reg_idx_t             idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = saag_pkg::reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r    <= saag_pkg::RESET_RANK;
      base_r    <= '0;
      sizes_r   <= saag_pkg::RESET_ONES;
      strides_r <= saag_pkg::RESET_ONES;
    end else if (wr_en) begin
      case (idx)
        saag_pkg::REG_RANK:    rank_r    <= pwdata[saag_pkg::RANK_BITS-1:0];
        saag_pkg::REG_BASE:    base_r    <= pwdata[saag_pkg::BASE_BITS-1:0];
        saag_pkg::REG_SIZES:   sizes_r   <= pwdata;
        saag_pkg::REG_STRIDES: strides_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      saag_pkg::REG_RANK:    prdata = {{(saag_pkg::DATA_BITS-saag_pkg::RANK_BITS){1'b0}}, rank_r};
      saag_pkg::REG_BASE:    prdata = {{(saag_pkg::DATA_BITS-saag_pkg::BASE_BITS){1'b0}}, base_r};
      saag_pkg::REG_SIZES:   prdata = sizes_r;
      saag_pkg::REG_STRIDES: prdata = strides_r;
      default:               prdata = '0;
    endcase
  end

  assign rank        = rank_r;
  assign base_offset = base_r;
  assign dim_sizes   = sizes_r;
  assign strides     = strides_r;

endmodule
`default_nettype wire

>>> sv/saag_ctrl.sv
`default_nettype none
module saag_ctrl #(
  parameter int MAX_RANK = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [saag_pkg::RANK_BITS-1:0]   rank,
  input  wire saag_pkg::dp_status_t             status,
  output logic                                  busy,
  output logic                                  done,
  output saag_pkg::ctrl_cmd_t                   cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_MAC   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [saag_pkg::DIM_BITS-1:0]       dim_r, dim_nxt;
  logic [saag_pkg::STEP_BITS-1:0]      step_r, step_nxt;
  logic [saag_pkg::MAC_CNT_BITS-1:0]   mac_r, mac_nxt;
  logic [saag_pkg::RANK_BITS-1:0]      rank_eff;

  // Clamp rank to the configured maximum.
  assign rank_eff = (rank > saag_pkg::RANK_BITS'(MAX_RANK)) ?
                    saag_pkg::RANK_BITS'(MAX_RANK) : rank;

  always_comb begin
    state_nxt   = state_r;
    dim_nxt     = dim_r;
    step_nxt    = step_r;
    mac_nxt     = mac_r;
    cmd         = '0;
    cmd.dim     = dim_r;
    cmd.mac_idx = mac_r[saag_pkg::DIM_BITS-1:0];
    cmd.mac_use = (mac_r < rank_eff);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          dim_nxt  = saag_pkg::DIM_BITS'(rank_eff - 3'd1);
          mac_nxt  = '0;
          state_nxt = (rank_eff == '0) ? S_MAC : S_SETUP;
        end
      end
      S_SETUP: begin
        if (status.size_zero) begin
          cmd.set_err = 1'b1;
          mac_nxt     = '0;
          state_nxt   = S_MAC;
        end else begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == saag_pkg::STEP_BITS'(saag_pkg::DIV_CYCLES - 1)) begin
          cmd.store = 1'b1;
          if (dim_r == '0) begin
            mac_nxt   = '0;
            state_nxt = S_MAC;
          end else begin
            dim_nxt   = dim_r - 1'b1;
            state_nxt = S_SETUP;
          end
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        mac_nxt      = mac_r + 1'b1;
        if (mac_r == rank_eff) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dim_r   <= '0;
      step_r  <= '0;
      mac_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      step_r  <= step_nxt;
      mac_r   <= mac_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule
`default_nettype wire

>>> sv/saag_dp.sv
`default_nettype none
module saag_dp #(
  parameter int MAX_RANK   = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire saag_pkg::ctrl_cmd_t                           cmd,
  input  wire logic [saag_pkg::INDEX_BITS-1:0]               flat_index,
  input  wire logic [saag_pkg::BASE_BITS-1:0]                base_offset,
  input  wire logic [saag_pkg::DATA_BITS-1:0]                dim_sizes,
  input  wire logic [saag_pkg::DATA_BITS-1:0]                strides,
  output saag_pkg::dp_status_t                               status,
  output logic [saag_pkg::OFFSET_BITS-1:0]                   element_offset,
  output logic [saag_pkg::SLOT_COUNT-1:0][saag_pkg::SLOT_BITS-1:0] coords,
  output logic                                               zero_dim_error
);

  logic [saag_pkg::INDEX_BITS-1:0]  q_r, q_nxt;
  logic [COORD_BITS-1:0]            rem_r, rem_nxt;
  logic [COORD_BITS:0]              shifted;
  logic [saag_pkg::SLOT_BITS-1:0]   size_slot;
  logic [COORD_BITS-1:0]            size;
  logic [COORD_BITS-1:0]            coord_r [MAX_RANK];
  logic                             err_r;
  logic [saag_pkg::OFFSET_BITS-1:0] acc_r;
  logic [saag_pkg::OFFSET_BITS-1:0] prod_r, prod_nxt;
  logic [COORD_BITS-1:0]            coord_sel;
  logic signed [saag_pkg::SLOT_BITS-1:0]       stride_sel;
  logic signed [COORD_BITS+saag_pkg::SLOT_BITS:0] prod_full;

  assign size_slot = saag_pkg::slot_of(dim_sizes, cmd.dim);
  assign size      = size_slot[COORD_BITS-1:0];
  assign status.size_zero = (size == '0);

  // Restoring divide, DIV_BITS_PER_CYCLE quotient bits per cycle; the quotient shifts in
  // behind the dividend so q_r ends up holding it.
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    shifted = '0;
    for (int i = 0; i < saag_pkg::DIV_BITS_PER_CYCLE; i++) begin
      shifted = {rem_nxt, q_nxt[saag_pkg::INDEX_BITS-1]};
      if (shifted >= {1'b0, size}) begin
        rem_nxt = COORD_BITS'(shifted - {1'b0, size});
        q_nxt   = {q_nxt[saag_pkg::INDEX_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[COORD_BITS-1:0];
        q_nxt   = {q_nxt[saag_pkg::INDEX_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    coord_sel = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (cmd.mac_idx == saag_pkg::DIM_BITS'(i)) begin
        coord_sel = coord_r[i];
      end
    end
  end

  assign stride_sel = $signed(saag_pkg::slot_of(strides, cmd.mac_idx));
  assign prod_full  = $signed({1'b0, coord_sel}) * stride_sel;
  assign prod_nxt   = cmd.mac_use ? saag_pkg::OFFSET_BITS'(prod_full) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r    <= flat_index;
      err_r  <= 1'b0;
      acc_r  <= {{(saag_pkg::OFFSET_BITS-saag_pkg::BASE_BITS){1'b0}}, base_offset};
      prod_r <= '0;
      for (int i = 0; i < MAX_RANK; i++) begin
        coord_r[i] <= '0;
      end
    end
    if (cmd.div_init) begin
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
    if (cmd.store) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        if (cmd.dim == saag_pkg::DIM_BITS'(i)) begin
          coord_r[i] <= rem_nxt;
        end
      end
    end
    if (cmd.set_err) begin
      err_r <= 1'b1;
    end
    if (cmd.mac_step) begin
      acc_r  <= acc_r + prod_r;
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    coords = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      coords[i] = saag_pkg::SLOT_BITS'(coord_r[i]);
    end
  end

  assign element_offset = acc_r;
  assign zero_dim_error = err_r;

endmodule
`default_nettype wire

>>> sv/strided_array_address_generator_unit.sv
`default_nettype none
// Strided array address generator. Pulse start while busy is low to hand in
// a request with in_flat_index; busy rises on the next cycle and the result
// shows on the out_ ports with out_strobe high for exactly one cycle. The
// receiver cannot stall, so sample every strobe. A request of effective rank
// r (rank clamped to MAX_RANK) keeps busy high up to and including the
// strobe: each dimension runs through the shared radix-2 divider at two
// quotient bits per cycle after a setup state, then one multiply-accumulate
// step per dimension plus one to drain the product register, then the
// strobe state. A zero size in use ends the division early and raises
// out_zero_dim_error. Program the registers over the APB port only while
// busy is low: rank at 0x00, base_offset at 0x08, dim_sizes at 0x10 and
// strides at 0x18, 64-bit data.
module strided_array_address_generator_unit #(
  parameter int MAX_RANK   = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // request channel
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [saag_pkg::INDEX_BITS-1:0]        in_flat_index,
  // result channel
  output logic                                        out_strobe,
  output logic signed [saag_pkg::OFFSET_BITS-1:0]     out_element_offset,
  output logic [saag_pkg::SLOT_BITS-1:0]              out_coord_0,
  output logic [saag_pkg::SLOT_BITS-1:0]              out_coord_1,
  output logic [saag_pkg::SLOT_BITS-1:0]              out_coord_2,
  output logic [saag_pkg::SLOT_BITS-1:0]              out_coord_3,
  output logic                                        out_zero_dim_error,
  // configuration port
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [saag_pkg::ADDR_BITS-1:0]         paddr,
  input  wire logic [saag_pkg::DATA_BITS-1:0]         pwdata,
  output logic [saag_pkg::DATA_BITS-1:0]              prdata,
  output logic                                        pready
);

  logic [saag_pkg::RANK_BITS-1:0]   rank;
  logic [saag_pkg::BASE_BITS-1:0]   base_offset;
  logic [saag_pkg::DATA_BITS-1:0]   dim_sizes;
  logic [saag_pkg::DATA_BITS-1:0]   strides;
  saag_pkg::ctrl_cmd_t              cmd;
  saag_pkg::dp_status_t             status;
  logic [saag_pkg::OFFSET_BITS-1:0] element_offset;
  logic [saag_pkg::SLOT_COUNT-1:0][saag_pkg::SLOT_BITS-1:0] coords;

  // Register file; hold values across requests.
  saag_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rank        (rank),
    .base_offset (base_offset),
    .dim_sizes   (dim_sizes),
    .strides     (strides)
  );

  // Sequencer: walk dimensions innermost first, then accumulate.
  saag_ctrl #(
    .MAX_RANK (MAX_RANK)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .rank   (rank),
    .status (status),
    .busy   (busy),
    .done   (out_strobe),
    .cmd    (cmd)
  );

  // Divider, coordinate store and stride multiply-accumulate.
  saag_dp #(
    .MAX_RANK   (MAX_RANK),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .flat_index     (in_flat_index),
    .base_offset    (base_offset),
    .dim_sizes      (dim_sizes),
    .strides        (strides),
    .status         (status),
    .element_offset (element_offset),
    .coords         (coords),
    .zero_dim_error (out_zero_dim_error)
  );

  assign out_element_offset = $signed(element_offset);
  assign out_coord_0        = coords[0];
  assign out_coord_1        = coords[1];
  assign out_coord_2        = coords[2];
  assign out_coord_3        = coords[3];

endmodule
`default_nettype wire
